// ===== src/skt_pkg.sv =====
`timescale 1ns / 1ps
package skt_pkg;

  // Table geometry, fixed by the widths of rank and entry_count
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_IN_W    = 16;
  localparam int RANK_W      = 4;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_ZERO     = 3'd4;
  localparam logic [2:0] ST_RANK     = 3'd5;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [KEY_IN_W-1:0] key;
    logic [RANK_W-1:0]   rank;
  } req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [KEY_IN_W-1:0] read_key;
    logic [CNT_W-1:0]    entry_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_INS_SHIFT,
    S_DEL_SHIFT,
    S_RDATA,
    S_DONE
  } state_t;

endpackage

// ===== src/skt_ram.sv =====
`timescale 1ns / 1ps
module skt_ram #(
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [skt_pkg::IDX_W-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [skt_pkg::IDX_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);
  import skt_pkg::*;

  logic [WIDTH-1:0] mem [TABLE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/sorted_key_table_core.sv =====
`timescale 1ns / 1ps
// Sorted key table: up to 16 unique nonzero keys held in ascending order in
// one single-port-read, single-port-write RAM.
// Request channel (req_valid, req_stall, req): opcode insert, delete or read
// at rank. A request is taken when req_valid is high and req_stall is low;
// req_stall is high while an operation is in progress.
// Response channel (rsp_valid, rsp_stall, rsp): one response per request with
// status, read_key (nonzero only on a good read) and the count after the
// operation. The response sits in an output register; a new request can be
// taken while it waits to be taken.
// A good read passes through a RAM read state before its response is loaded;
// a rejected read, an unused opcode or a zero key goes straight to the
// response. Insert and delete of a nonzero key run a binary search over the
// held keys, one probe state and one compare state per probe (at most 5
// probes), then, if the key is added or removed, move the larger keys one
// slot through the RAM, one key per cycle. The block takes one request at a
// time; the next request is taken on the edge after the response is loaded.
// Reset empties the table through the count alone; RAM contents are don't
// care. When the receiver stalls, the response holds and the block finishes
// at most one more operation before it waits for the output register.
module sorted_key_table_core #(
  parameter int KEY_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  skt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output skt_pkg::rsp_t rsp
);
  import skt_pkg::*;

  localparam int KW_IN = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;

  state_t state, state_next;

  logic [1:0]           op;
  logic [KEY_WIDTH-1:0] key_r;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     lo;
  logic [CNT_W-1:0]     hi;
  logic [IDX_W-1:0]     mid;
  logic [IDX_W-1:0]     pos;
  logic                 found;
  logic [CNT_W-1:0]     sp;
  logic                 pend;
  logic [IDX_W-1:0]     waddr;
  logic [2:0]           status_r;
  logic [KEY_WIDTH-1:0] rkey_r;

  logic [KEY_WIDTH-1:0] key_in;
  logic                 accept;
  logic                 search_on;
  logic [CNT_W:0]       mid_sum;
  logic [CNT_W-1:0]     mid_calc;
  logic [CNT_W-1:0]     sp_dec;
  logic                 out_free;
  logic                 rank_ok;

  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [KEY_WIDTH-1:0] rd_data;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;

  skt_ram #(.WIDTH(KEY_WIDTH)) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Decode request and search helpers
  assign key_in    = KEY_WIDTH'(req.key[KW_IN-1:0]);
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign search_on = (lo < hi) && !found;
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid_calc  = mid_sum[CNT_W:1];
  assign sp_dec    = sp - 1'b1;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign rank_ok   = CNT_W'(req.rank) < count;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.opcode)
            OP_INSERT,
            OP_DELETE: state_next = (key_in == '0) ? S_DONE : S_PROBE;
            OP_READ:   state_next = rank_ok ? S_RDATA : S_DONE;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_PROBE: begin
        if (search_on) begin
          state_next = S_CMP;
        end else if (op == OP_INSERT) begin
          if (found || count == CNT_W'(TABLE_DEPTH)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_INS_SHIFT;
          end
        end else begin
          state_next = found ? S_DEL_SHIFT : S_DONE;
        end
      end
      S_CMP: state_next = S_PROBE;
      S_INS_SHIFT: begin
        if (sp == lo && !pend) begin
          state_next = S_DONE;
        end
      end
      S_DEL_SHIFT: begin
        if (sp == count && !pend) begin
          state_next = S_DONE;
        end
      end
      S_RDATA: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mid_calc[IDX_W-1:0];
    wr_en   = pend;
    wr_addr = waddr;
    wr_data = rd_data;
    case (state)
      S_IDLE: begin
        rd_en   = accept && (req.opcode == OP_READ) && rank_ok;
        rd_addr = IDX_W'(req.rank);
      end
      S_PROBE: begin
        rd_en   = search_on;
        rd_addr = mid_calc[IDX_W-1:0];
      end
      S_INS_SHIFT: begin
        if (sp > lo) begin
          rd_en   = 1'b1;
          rd_addr = sp_dec[IDX_W-1:0];
        end else if (!pend) begin
          wr_en   = 1'b1;
          wr_addr = lo[IDX_W-1:0];
          wr_data = key_r;
        end
      end
      S_DEL_SHIFT: begin
        if (sp < count) begin
          rd_en   = 1'b1;
          rd_addr = sp[IDX_W-1:0];
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_INS_SHIFT: begin
          if (sp > lo) begin
            pend <= 1'b1;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            count <= count + 1'b1;
          end
        end
        S_DEL_SHIFT: begin
          if (sp < count) begin
            pend <= 1'b1;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            count <= count - 1'b1;
          end
        end
        default: pend <= 1'b0;
      endcase
      // Drop the response once taken, load a new one when done
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Operation datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op       <= req.opcode;
        key_r    <= key_in;
        lo       <= '0;
        hi       <= count;
        found    <= 1'b0;
        rkey_r   <= '0;
        status_r <= ST_OK;
        if (key_in == '0 && (req.opcode == OP_INSERT || req.opcode == OP_DELETE)) begin
          status_r <= ST_ZERO;
        end else if (req.opcode == OP_READ && !rank_ok) begin
          status_r <= ST_RANK;
        end
      end
      S_PROBE: begin
        mid <= mid_calc[IDX_W-1:0];
        if (!search_on) begin
          if (op == OP_INSERT) begin
            sp <= count;
            if (found) begin
              status_r <= ST_DUP;
            end else if (count == CNT_W'(TABLE_DEPTH)) begin
              status_r <= ST_FULL;
            end
          end else begin
            sp <= CNT_W'(pos) + 1'b1;
            if (!found) begin
              status_r <= ST_NOTFOUND;
            end
          end
        end
      end
      S_CMP: begin
        if (rd_data == key_r) begin
          found <= 1'b1;
          pos   <= mid;
        end else if (rd_data < key_r) begin
          lo <= CNT_W'(mid) + 1'b1;
        end else begin
          hi <= CNT_W'(mid);
        end
      end
      S_INS_SHIFT: begin
        if (sp > lo) begin
          waddr <= sp[IDX_W-1:0];
          sp    <= sp_dec;
        end
      end
      S_DEL_SHIFT: begin
        if (sp < count) begin
          waddr <= sp_dec[IDX_W-1:0];
          sp    <= sp + 1'b1;
        end
      end
      S_RDATA: begin
        rkey_r <= rd_data;
      end
      S_DONE: begin
        if (out_free) begin
          rsp.status      <= status_r;
          rsp.read_key    <= KEY_IN_W'(rkey_r);
          rsp.entry_count <= count;
        end
      end
      default: begin
        found <= found;
      end
    endcase
  end

endmodule

// ===== tb/sv/sorted_key_table_core_tb.sv =====
`timescale 1ns / 1ps
module sorted_key_table_core_tb;
  import skt_pkg::*;

  // Opcode 3 has no name in the package; it must leave the table alone
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int RANDOM_REQUESTS = 625;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRESSURE_AT = 120;
  localparam int PRESSURE_LEN = 300;

  typedef struct {
    req_t cmd;
    int   reps;
    bit   typed;
    rsp_t want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // Shadow copy of the sorted table
  logic [KEY_IN_W-1:0] held_keys [TABLE_DEPTH];
  int unsigned         held_n;

  rsp_t      awaited_rsp [$];
  plan_row_t plan [$];
  int        mismatches;
  int        items_sent;
  int        rsp_taken;
  int        cycle_count;

  sorted_key_table_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int slot_of(logic [KEY_IN_W-1:0] k);
    for (int p = 0; p < held_n; p++) begin
      if (held_keys[p] == k) return p;
    end
    return -1;
  endfunction

  // Apply one request to the shadow table and return its response
  function automatic rsp_t table_apply(req_t cmd);
    rsp_t o;
    int   pos;
    o.status   = ST_OK;
    o.read_key = '0;
    case (cmd.opcode)
      OP_INSERT: begin
        if (cmd.key == '0) begin
          o.status = ST_ZERO;
        end else if (slot_of(cmd.key) >= 0) begin
          o.status = ST_DUP;
        end else if (held_n >= TABLE_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_n && held_keys[pos] < cmd.key) pos++;
          for (int j = held_n; j > pos; j--) held_keys[j] = held_keys[j-1];
          held_keys[pos] = cmd.key;
          held_n++;
        end
      end
      OP_DELETE: begin
        pos = slot_of(cmd.key);
        if (cmd.key == '0) begin
          o.status = ST_ZERO;
        end else if (pos < 0) begin
          o.status = ST_NOTFOUND;
        end else begin
          for (int j = pos; j + 1 < held_n; j++) held_keys[j] = held_keys[j+1];
          held_n--;
          held_keys[held_n] = '0;
        end
      end
      OP_READ: begin
        if (cmd.rank < held_n) o.read_key = held_keys[cmd.rank];
        else o.status = ST_RANK;
      end
      default: ;
    endcase
    o.entry_count = held_n[CNT_W-1:0];
    return o;
  endfunction

  // Mostly short gaps, a few long ones, none inside the calm window
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (items_sent >= 300 && items_sent < 380) return 0;
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Alternate fill and drain phases so the table swings between empty and full
  function automatic req_t random_request(int idx);
    req_t cmd;
    int   r;
    bit   filling;
    filling = ((idx / 90) % 2) == 0;
    r = $urandom_range(0, 99);
    if (filling) begin
      cmd.opcode = (r < 60) ? OP_INSERT : (r < 80) ? OP_DELETE : (r < 97) ? OP_READ : OP_NOP;
    end else begin
      cmd.opcode = (r < 20) ? OP_INSERT : (r < 80) ? OP_DELETE : (r < 97) ? OP_READ : OP_NOP;
    end
    r = $urandom_range(0, 99);
    if (cmd.opcode == OP_DELETE && held_n > 0 && r < 60) begin
      cmd.key = held_keys[$urandom_range(0, held_n - 1)];
    end else if (r < 8) begin
      cmd.key = '0;
    end else if (r < 60) begin
      cmd.key = KEY_IN_W'($urandom_range(1, 48));
    end else if (r < 80 && held_n > 0) begin
      cmd.key = held_keys[$urandom_range(0, held_n - 1)];
    end else begin
      cmd.key = KEY_IN_W'($urandom);
    end
    cmd.rank = RANK_W'($urandom_range(0, 15));
    return cmd;
  endfunction

  function automatic void add_row(logic [1:0] op, logic [KEY_IN_W-1:0] k, logic [RANK_W-1:0] rk,
                                  int reps, bit typed, logic [2:0] st,
                                  logic [KEY_IN_W-1:0] rdk, logic [CNT_W-1:0] cnt);
    plan_row_t row;
    row.cmd.opcode        = op;
    row.cmd.key           = k;
    row.cmd.rank          = rk;
    row.reps              = reps;
    row.typed             = typed;
    row.want.status       = st;
    row.want.read_key     = rdk;
    row.want.entry_count  = cnt;
    plan.push_back(row);
  endfunction

  // Offer one request, hold it until taken, then record its expected response
  task automatic offer(input req_t cmd, input bit typed, input rsp_t typed_rsp);
    rsp_t predicted;
    int   gap;
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= cmd;
    do @(posedge clk); while (req_stall);
    predicted = table_apply(cmd);
    awaited_rsp.push_back(typed ? typed_rsp : predicted);
    items_sent++;
    gap = idle_cycles();
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drive the response stall, with one long hold-off to back up the block
  initial begin
    int  hold_left;
    bit  pressure_done;
    int  n;
    hold_left     = 0;
    pressure_done = 1'b0;
    rsp_stall     = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (!pressure_done && rsp_taken >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_left     = PRESSURE_LEN - 1;
        rsp_stall    <= 1'b1;
      end else begin
        n = idle_cycles();
        rsp_stall <= (n > 0);
        if (n > 0) hold_left = n - 1;
      end
    end
  end

  // Compare each taken response with the oldest expectation
  initial begin
    rsp_t want;
    rsp_taken  = 0;
    mismatches = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        rsp_taken++;
        if (awaited_rsp.size() == 0) begin
          $error("response with none outstanding: status %0d read_key %h entry_count %0d",
                 rsp.status, rsp.read_key, rsp.entry_count);
          mismatches++;
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            mismatches++;
          end
          if (rsp.read_key !== want.read_key) begin
            $error("read_key: expected %h, got %h", want.read_key, rsp.read_key);
            mismatches++;
          end
          if (rsp.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, rsp.entry_count);
            mismatches++;
          end
        end
      end
    end
  end

  // Bound the run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sorted_key_table_core_tb NOT OK");
    $finish;
  end

  initial begin
    req_t cmd;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    items_sent = 0;
    held_n     = 0;
    for (int p = 0; p < TABLE_DEPTH; p++) held_keys[p] = '0;

    // Empty table, zero keys and the unused opcode
    add_row(OP_READ,   16'h0000, 4'd0,  1, 1'b1, ST_RANK,     16'h0000, 5'd0);
    add_row(OP_DELETE, 16'h0005, 4'd0,  1, 1'b1, ST_NOTFOUND, 16'h0000, 5'd0);
    add_row(OP_INSERT, 16'h0000, 4'd15, 1, 1'b1, ST_ZERO,     16'h0000, 5'd0);
    add_row(OP_DELETE, 16'h0000, 4'd0,  1, 1'b1, ST_ZERO,     16'h0000, 5'd0);
    add_row(OP_NOP,    16'hFFFF, 4'd15, 1, 1'b1, ST_OK,       16'h0000, 5'd0);
    // Extreme keys, duplicate, reads in and beyond the count
    add_row(OP_INSERT, 16'hFFFF, 4'd0,  1, 1'b1, ST_OK,       16'h0000, 5'd1);
    add_row(OP_INSERT, 16'h0001, 4'd0,  1, 1'b1, ST_OK,       16'h0000, 5'd2);
    add_row(OP_INSERT, 16'hFFFF, 4'd0,  1, 1'b1, ST_DUP,      16'h0000, 5'd2);
    add_row(OP_READ,   16'h0000, 4'd0,  1, 1'b1, ST_OK,       16'h0001, 5'd2);
    add_row(OP_READ,   16'h0000, 4'd1,  1, 1'b1, ST_OK,       16'hFFFF, 5'd2);
    add_row(OP_READ,   16'hFFFF, 4'd15, 1, 1'b1, ST_RANK,     16'h0000, 5'd2);
    // Fill with 0x0100, 0x0200 ... 0x0E00, landing between the extremes
    add_row(OP_INSERT, 16'h0100, 4'd0, 14, 1'b0, ST_OK,       16'h0000, 5'd0);
    add_row(OP_INSERT, 16'h0050, 4'd0,  1, 1'b1, ST_FULL,     16'h0000, 5'd16);
    add_row(OP_INSERT, 16'h0001, 4'd0,  1, 1'b1, ST_DUP,      16'h0000, 5'd16);
    add_row(OP_INSERT, 16'h0000, 4'd0,  1, 1'b1, ST_ZERO,     16'h0000, 5'd16);
    add_row(OP_READ,   16'h0000, 4'd15, 1, 1'b1, ST_OK,       16'hFFFF, 5'd16);
    add_row(OP_READ,   16'h0000, 4'd0,  1, 1'b1, ST_OK,       16'h0001, 5'd16);
    // Delete smallest, largest and a middle key, then a missing one
    add_row(OP_DELETE, 16'h0001, 4'd0,  1, 1'b1, ST_OK,       16'h0000, 5'd15);
    add_row(OP_DELETE, 16'hFFFF, 4'd0,  1, 1'b1, ST_OK,       16'h0000, 5'd14);
    add_row(OP_DELETE, 16'h0700, 4'd0,  1, 1'b1, ST_OK,       16'h0000, 5'd13);
    add_row(OP_DELETE, 16'h0700, 4'd0,  1, 1'b1, ST_NOTFOUND, 16'h0000, 5'd13);
    add_row(OP_READ,   16'h0000, 4'd13, 1, 1'b1, ST_RANK,     16'h0000, 5'd13);
    add_row(OP_READ,   16'h0000, 4'd12, 1, 1'b1, ST_OK,       16'h0E00, 5'd13);
    add_row(OP_READ,   16'h0000, 4'd6,  1, 1'b0, ST_OK,       16'h0000, 5'd0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed plan; repeated rows scale the key by the repeat number
    foreach (plan[r]) begin
      for (int i = 0; i < plan[r].reps; i++) begin
        cmd     = plan[r].cmd;
        cmd.key = KEY_IN_W'(plan[r].cmd.key * (i + 1));
        offer(cmd, plan[r].typed, plan[r].want);
      end
    end

    for (int i = 0; i < RANDOM_REQUESTS; i++) offer(random_request(i), 1'b0, '0);

    @(negedge clk);
    req_valid <= 1'b0;

    // Drain, then give stray responses time to show up
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("sorted_key_table_core_tb OK");
    end else begin
      $display("sorted_key_table_core_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sorted_key_table_core.f =====
src/skt_pkg.sv
src/skt_ram.sv
src/sorted_key_table_core.sv
tb/sv/sorted_key_table_core_tb.sv
